### rtl/stp_pkg.sv
// Shared constants and types for the screen tile partitioner.
package stp_pkg;

    localparam int unsigned MAX_TILES_DEF     = 64;
    localparam int unsigned SHADE_ENTRIES_DEF = 32;
    localparam int unsigned DIM_W             = 14;
    localparam int unsigned POS_W             = 13;
    localparam int unsigned CNT_W             = 7;
    localparam int unsigned IDX_W             = 6;
    localparam int unsigned GREY_W            = 8;
    localparam int unsigned AREA_W            = 27;
    localparam int unsigned DIM_MAX           = 8192;

    typedef enum logic [2:0] {
        DIV_AREA_CNT,
        DIV_SW_SIDE,
        DIV_CNT_COLS,
        DIV_TSW_CNT,
        DIV_SH_T
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     col_init;
        logic     col_setup;
        logic     tile_adv;
    } stp_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic div_done;
        logic sqrt_done;
        logic side_zero;
        logic cols_bad;
        logic last_row;
        logic last_col;
    } stp_sts_t;

endpackage

### rtl/screen_tile_partitioner_unit.sv
// Top level of the screen tile partitioner.
//
// channel  | ports | direction | contents
// request  | s_*   | in        | screen_width, screen_height, tile_count
// tile     | m_*   | out       | one transfer per tile, or one error transfer
//
// Setup runs three divides and the root after the request transfer. Each column
// then needs two divides before its tiles leave at one per cycle while m_ready.
// The shared bit-serial divider sets the pace. One request is in work at a time.
// Reset is synchronous, active low, and returns the controller to idle.
// A stalled m_ready holds the current tile; s_ready stays low until the last transfer.
module screen_tile_partitioner_unit #(
    parameter int unsigned MAX_TILES     = stp_pkg::MAX_TILES_DEF,
    parameter int unsigned SHADE_ENTRIES = stp_pkg::SHADE_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [stp_pkg::DIM_W-1:0]    s_screen_width,
    input  logic [stp_pkg::DIM_W-1:0]    s_screen_height,
    input  logic [stp_pkg::CNT_W-1:0]    s_tile_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [stp_pkg::IDX_W-1:0]    m_tile_index,
    output logic [stp_pkg::POS_W-1:0]    m_tile_x,
    output logic [stp_pkg::POS_W-1:0]    m_tile_y,
    output logic [stp_pkg::DIM_W-1:0]    m_tile_width,
    output logic [stp_pkg::DIM_W-1:0]    m_tile_height,
    output logic [stp_pkg::GREY_W-1:0]   m_grey_level,
    output logic                         m_error_flag,
    output logic                         m_last_tile
);
    stp_pkg::stp_cmd_t cmd;
    stp_pkg::stp_sts_t sts;
    logic err;
    logic [stp_pkg::IDX_W-1:0]  d_index;
    logic [stp_pkg::POS_W-1:0]  d_x, d_y;
    logic [stp_pkg::DIM_W-1:0]  d_w, d_h;
    logic [stp_pkg::GREY_W-1:0] d_grey;
    logic d_last;

    stp_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .out_err(err), .cmd(cmd), .sts(sts)
    );

    stp_datapath #(.MAX_TILES(MAX_TILES), .SHADE_ENTRIES(SHADE_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_width(s_screen_width), .in_height(s_screen_height), .in_count(s_tile_count),
        .o_index(d_index), .o_x(d_x), .o_y(d_y), .o_width(d_w), .o_height(d_h),
        .o_grey(d_grey), .o_last(d_last)
    );

    assign m_tile_index  = err ? '0 : d_index;
    assign m_tile_x      = err ? '0 : d_x;
    assign m_tile_y      = err ? '0 : d_y;
    assign m_tile_width  = err ? '0 : d_w;
    assign m_tile_height = err ? '0 : d_h;
    assign m_grey_level  = err ? '0 : d_grey;
    assign m_error_flag  = err;
    assign m_last_tile   = err | d_last;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while result pending");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_flag) |-> m_last_tile) else $error("error not last");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_tile) |=> s_ready) else $error("no return to idle");
endmodule

### rtl/stp_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module stp_divider #(
    parameter int unsigned W = 27
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] n_reg, n_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            n_next    = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        n_reg <= n_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

### rtl/stp_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module stp_sqrt #(
    parameter int unsigned W = 28
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   radicand,
    output logic           done,
    output logic [W/2-1:0] root
);
    localparam int unsigned H  = W / 2;
    localparam int unsigned CW = $clog2(H + 1);

    logic [W-1:0]  v_reg, v_next;
    logic [H+1:0]  rem_reg, rem_next;
    logic [H-1:0]  r_reg, r_next;
    logic [CW-1:0] n_reg, n_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [H+1:0]  cur, trial;

    always_comb begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cur       = {rem_reg[H-1:0], v_reg[W-1:W-2]};
        trial     = {r_reg, 2'b01};
        if (start) begin
            v_next    = radicand;
            rem_next  = '0;
            r_next    = '0;
            n_next    = CW'(H);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = {v_reg[W-3:0], 2'b00};
            if (cur >= trial) begin
                rem_next = cur - trial;
                r_next   = {r_reg[H-2:0], 1'b1};
            end else begin
                rem_next = cur;
                r_next   = {r_reg[H-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg   <= v_next;
        rem_reg <= rem_next;
        r_reg   <= r_next;
        n_reg   <= n_next;
    end

    assign done = done_reg;
    assign root = r_reg;
endmodule

### rtl/stp_datapath.sv
// Datapath: operand registers, shared divider and root unit, tile walk.
module stp_datapath #(
    parameter int unsigned MAX_TILES     = stp_pkg::MAX_TILES_DEF,
    parameter int unsigned SHADE_ENTRIES = stp_pkg::SHADE_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  stp_pkg::stp_cmd_t            cmd,
    output stp_pkg::stp_sts_t            sts,
    input  logic [stp_pkg::DIM_W-1:0]    in_width,
    input  logic [stp_pkg::DIM_W-1:0]    in_height,
    input  logic [stp_pkg::CNT_W-1:0]    in_count,
    output logic [stp_pkg::IDX_W-1:0]    o_index,
    output logic [stp_pkg::POS_W-1:0]    o_x,
    output logic [stp_pkg::POS_W-1:0]    o_y,
    output logic [stp_pkg::DIM_W-1:0]    o_width,
    output logic [stp_pkg::DIM_W-1:0]    o_height,
    output logic [stp_pkg::GREY_W-1:0]   o_grey,
    output logic                         o_last
);
    localparam int unsigned DW = stp_pkg::DIM_W;
    localparam int unsigned CN = stp_pkg::CNT_W;
    localparam int unsigned AW = stp_pkg::AREA_W;
    localparam int unsigned SW = 28;

    logic [DW-1:0] sw_reg, sh_reg, x_reg, cw_reg, rh_reg, y_reg;
    logic [CN-1:0] cnt_reg, cols_reg, base_reg, extra_reg, col_reg, t_reg, j_reg;
    logic [CN-1:0] k_reg, shd_reg;
    logic [AW-1:0] area_reg, tsw_reg;
    stp_pkg::div_sel_t op_reg;

    logic [AW-1:0] dv_a, dv_b, dv_q, dv_r;
    logic          dv_done;
    logic [SW/2-1:0] sq_root;
    logic          sq_done;
    logic [CN-1:0] t_now;
    logic [DW-1:0] cw_fix;
    logic [AW-1:0] tsw_mul;

    always_comb begin
        case (cmd.div_sel)
            stp_pkg::DIV_AREA_CNT: begin dv_a = area_reg; dv_b = AW'(cnt_reg); end
            stp_pkg::DIV_SW_SIDE:  begin dv_a = AW'(sw_reg); dv_b = AW'(sq_root); end
            stp_pkg::DIV_CNT_COLS: begin dv_a = AW'(cnt_reg); dv_b = AW'(cols_reg); end
            stp_pkg::DIV_TSW_CNT:  begin dv_a = tsw_reg; dv_b = AW'(cnt_reg); end
            stp_pkg::DIV_SH_T:     begin dv_a = AW'(sh_reg); dv_b = AW'(t_reg); end
            default:               begin dv_a = '0; dv_b = '1; end
        endcase
    end

    stp_divider #(.W(AW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(dv_a), .divisor(dv_b), .done(dv_done),
        .quotient(dv_q), .remainder(dv_r)
    );

    stp_sqrt #(.W(SW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.sqrt_start),
        .radicand(SW'(dv_q)), .done(sq_done), .root(sq_root)
    );

    assign t_now   = (extra_reg != '0) ? base_reg + 1'b1 : base_reg;
    assign tsw_mul = AW'(t_now) * AW'(sw_reg);
    assign cw_fix  = (col_reg == cols_reg - 1'b1) ? sw_reg - x_reg
                                                  : {dv_q[DW-1:3], 3'b000};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sw_reg   <= in_width;
            sh_reg   <= in_height;
            cnt_reg  <= in_count;
            area_reg <= AW'(in_width) * AW'(in_height);
        end
        if (cmd.div_start)
            op_reg <= cmd.div_sel;
        if (op_reg == stp_pkg::DIV_SW_SIDE && dv_done)
            cols_reg <= CN'(dv_q);
        if (cmd.col_init) begin
            base_reg <= CN'(dv_q);
            extra_reg <= CN'(dv_r);
            col_reg  <= '0;
            x_reg    <= '0;
            k_reg    <= '0;
            shd_reg  <= '0;
        end
        if (cmd.col_setup) begin
            t_reg   <= t_now;
            tsw_reg <= tsw_mul;
            if (extra_reg != '0)
                extra_reg <= extra_reg - 1'b1;
        end
        if (op_reg == stp_pkg::DIV_TSW_CNT && dv_done)
            cw_reg <= cw_fix;
        if (op_reg == stp_pkg::DIV_SH_T && dv_done) begin
            rh_reg <= DW'(dv_q);
            y_reg  <= '0;
            j_reg  <= '0;
        end
        if (cmd.tile_adv) begin
            k_reg   <= k_reg + 1'b1;
            shd_reg <= (shd_reg == CN'(SHADE_ENTRIES - 1)) ? '0 : shd_reg + 1'b1;
            if (j_reg == t_reg - 1'b1) begin
                x_reg   <= x_reg + cw_reg;
                col_reg <= col_reg + 1'b1;
            end else begin
                j_reg <= j_reg + 1'b1;
                y_reg <= y_reg + rh_reg;
            end
        end
    end

    always_comb begin
        sts.in_bad = (in_count == '0) || (in_count > CN'(MAX_TILES)) ||
                     (in_width == '0) || (in_height == '0) ||
                     (in_width > DW'(stp_pkg::DIM_MAX)) ||
                     (in_height > DW'(stp_pkg::DIM_MAX));
        sts.div_done  = dv_done;
        sts.sqrt_done = sq_done;
        sts.side_zero = (sq_root == '0);
        sts.cols_bad  = (dv_q == '0) || (dv_q > AW'(cnt_reg));
        sts.last_row  = (j_reg == t_reg - 1'b1);
        sts.last_col  = (col_reg == cols_reg - 1'b1);
    end

    logic [CN+2:0] grey_raw;
    assign grey_raw = (CN+3)'(shd_reg + 1'b1) << 3;

    assign o_index  = stp_pkg::IDX_W'(k_reg);
    assign o_x      = stp_pkg::POS_W'(x_reg);
    assign o_y      = stp_pkg::POS_W'(y_reg);
    assign o_width  = cw_reg;
    assign o_height = sts.last_row ? sh_reg - y_reg : rh_reg;
    assign o_grey   = (grey_raw > (CN+3)'(255)) ? 8'd255 : 8'(grey_raw);
    assign o_last   = (k_reg + 1'b1 == cnt_reg);
endmodule

### rtl/stp_controller.sv
// Controller state machine sequencing setup, columns and tile emission.
module stp_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_err,
    output stp_pkg::stp_cmd_t cmd,
    input  stp_pkg::stp_sts_t sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_AREA, S_SQRT, S_COLS, S_BASE, S_CSET, S_CW, S_RH, S_EMIT, S_ERR
    } state_t;

    state_t state_reg, state_next;
    stp_pkg::div_sel_t sel_reg, sel_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT) || (state_reg == S_ERR);
    assign out_err   = (state_reg == S_ERR);

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.load = 1'b1;
                if (sts.in_bad) state_next = S_ERR;
                else state_next = S_AREA;
            end
            S_AREA: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = stp_pkg::DIV_AREA_CNT;
                sel_next      = stp_pkg::DIV_AREA_CNT;
                state_next    = S_SQRT;
            end
            S_SQRT: begin
                if (sts.div_done) cmd.sqrt_start = 1'b1;
                if (sts.sqrt_done) begin
                    if (sts.side_zero) state_next = S_ERR;
                    else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = stp_pkg::DIV_SW_SIDE;
                        sel_next      = stp_pkg::DIV_SW_SIDE;
                        state_next    = S_COLS;
                    end
                end
            end
            S_COLS: if (sts.div_done) begin
                if (sts.cols_bad) state_next = S_ERR;
                else state_next = S_BASE;
            end
            S_BASE: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = stp_pkg::DIV_CNT_COLS;
                sel_next      = stp_pkg::DIV_CNT_COLS;
                if (sts.div_done) begin
                    cmd.div_start = 1'b0;
                    cmd.col_init  = 1'b1;
                    state_next    = S_CSET;
                end else if (sel_reg == stp_pkg::DIV_CNT_COLS) begin
                    cmd.div_start = 1'b0;
                end
            end
            S_CSET: begin
                cmd.col_setup = 1'b1;
                state_next    = S_CW;
            end
            S_CW: begin
                cmd.div_sel = stp_pkg::DIV_TSW_CNT;
                if (sel_reg != stp_pkg::DIV_TSW_CNT) begin
                    cmd.div_start = 1'b1;
                    sel_next      = stp_pkg::DIV_TSW_CNT;
                end else if (sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = stp_pkg::DIV_SH_T;
                    sel_next      = stp_pkg::DIV_SH_T;
                    state_next    = S_RH;
                end
            end
            S_RH: if (sts.div_done) state_next = S_EMIT;
            S_EMIT: if (out_ready) begin
                cmd.tile_adv  = 1'b1;
                if (sts.last_row) begin
                    if (sts.last_col) state_next = S_IDLE;
                    else state_next = S_CSET;
                end
            end
            S_ERR: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= stp_pkg::DIV_AREA_CNT;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end
endmodule
